@@ design/modular_arithmetic_unit_defines.svh @@
// Assertion macros shared by the modular arithmetic unit modules.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MAU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/mau_pkg.sv @@
// Shared types, codes and helper functions of the modular arithmetic unit.
`default_nettype none
package mau_pkg;
	localparam int W = 32;
	localparam int CNT_W = $clog2(W + 1);

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_NEG = 3'd3;
	localparam logic [2:0] OP_INV = 3'd4;

	typedef logic [W-1:0] word_t;

	typedef enum logic [1:0] {DIV_A, DIV_B, DIV_R} div_sel_t;
	typedef enum logic [2:0] {RES_ZERO, RES_ADD, RES_SUB, RES_NEG, RES_ACC, RES_T1} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_step;
		logic     save_ar;
		logic     save_br;
		logic     mul_start;
		logic     mul_inv;
		logic     mul_dbl;
		logic     mul_add;
		logic     inv_init;
		logic     inv_upd;
		logic     set_res;
		res_sel_t res_sel;
		logic     res_st;
		logic     out_load;
	} mau_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       n_zero;
		logic       a_ge_n;
		logic       r2_zero;
		logic       r1_one;
	} mau_sts_t;

	// x, y < n
	function automatic word_t add_mod(word_t x, word_t y, word_t n);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, n})
			s = s - {1'b0, n};
		return s[W-1:0];
	endfunction

	// x, y < n; wraps through 2^W when y > x
	function automatic word_t sub_mod(word_t x, word_t y, word_t n);
		word_t d;
		d = x - y;
		if (x < y)
			d = d + n;
		return d;
	endfunction
endpackage
`default_nettype wire

@@ design/modular_arithmetic_unit.sv @@
// Modular arithmetic unit over Zn: add, subtract, multiply, negate and Euclid inverse.
// One item at a time. Unless the modulus is zero or the operation code is
// reserved, every item first reduces both operands with a 1-bit-per-cycle
// divider; then add/sub/negate pick their result directly, multiply runs a
// double-and-add loop, and the inverse runs one extended Euclid round per
// remainder step, each a division plus a modular multiply (up to ~46 rounds
// for 32-bit values). A finished result waits in an output register, so in_ready
// returns while it is still pending. The modulus register resets to 2 and is
// written through cfg_valid/cfg_data; write it only while the unit is idle.
`default_nettype none
module modular_arithmetic_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire mau_pkg::word_t cfg_data,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [2:0]     operation,
	input  wire mau_pkg::word_t operand_a,
	input  wire mau_pkg::word_t operand_b,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mau_pkg::word_t      result,
	output logic                status
);
	import mau_pkg::*;

	word_t     modulus_q;
	mau_cmd_t  cmd;
	mau_sts_t  sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			modulus_q <= word_t'(2);
		else if (cfg_valid)
			modulus_q <= cfg_data;
	end

	mau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mau_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.modulus   (modulus_q),
		.operation (operation),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result),
		.status    (status)
	);
endmodule
`default_nettype wire

@@ design/mau_datapath.sv @@
// Datapath: operand registers, shift-subtract divider, shift-add modular multiplier, Euclid state.
`default_nettype none
`include "modular_arithmetic_unit_defines.svh"
module mau_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mau_pkg::word_t   modulus,
	input  wire logic [2:0]       operation,
	input  wire mau_pkg::word_t   operand_a,
	input  wire mau_pkg::word_t   operand_b,
	input  wire mau_pkg::mau_cmd_t cmd,
	output mau_pkg::mau_sts_t     sts,
	output mau_pkg::word_t        result,
	output logic                  status
);
	import mau_pkg::*;

	logic [2:0] op_q;
	word_t a_q, b_q, ar_q, br_q;
	word_t r1_q, r2_q, t1_q, t2_q;
	word_t acc_q, mx_q, my_q;
	word_t dv_q, dd_q, rem_q, quo_q;
	word_t res_q, result_q;
	logic  st_q, status_q;

	logic [W:0] rem_w, rem_sub;
	logic       rem_ge;
	word_t      qm, res_d;

	assign rem_w   = {rem_q, dv_q[W-1]};
	assign rem_ge  = rem_w >= {1'b0, dd_q};
	assign rem_sub = rem_w - {1'b0, dd_q};
	// quotient reaches n only for r1 = n, r2 = 1
	assign qm      = (quo_q >= modulus) ? quo_q - modulus : quo_q;

	always_comb begin
		case (cmd.res_sel)
			RES_ADD: res_d = add_mod(ar_q, br_q, modulus);
			RES_SUB: res_d = sub_mod(ar_q, br_q, modulus);
			RES_NEG: res_d = (ar_q == '0) ? '0 : modulus - ar_q;
			RES_ACC: res_d = acc_q;
			RES_T1:  res_d = t1_q;
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			a_q  <= operand_a;
			b_q  <= operand_b;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= '0;
			case (cmd.div_sel)
				DIV_A: begin dv_q <= a_q;  dd_q <= modulus; end
				DIV_B: begin dv_q <= b_q;  dd_q <= modulus; end
				DIV_R: begin dv_q <= r1_q; dd_q <= r2_q;    end
				default: begin dv_q <= a_q; dd_q <= modulus; end
			endcase
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[W-1:0] : rem_w[W-1:0];
			quo_q <= {quo_q[W-2:0], rem_ge};
			dv_q  <= {dv_q[W-2:0], 1'b0};
		end
		if (cmd.save_ar)
			ar_q <= rem_q;
		if (cmd.save_br)
			br_q <= rem_q;
		if (cmd.mul_start) begin
			acc_q <= '0;
			mx_q  <= cmd.mul_inv ? qm : ar_q;
			my_q  <= cmd.mul_inv ? t2_q : br_q;
		end else if (cmd.mul_dbl) begin
			acc_q <= add_mod(acc_q, acc_q, modulus);
		end else if (cmd.mul_add) begin
			if (my_q[W-1])
				acc_q <= add_mod(acc_q, mx_q, modulus);
			my_q <= {my_q[W-2:0], 1'b0};
		end
		if (cmd.inv_init) begin
			r1_q <= modulus;
			r2_q <= a_q;
			t1_q <= '0;
			t2_q <= (modulus == word_t'(1)) ? '0 : word_t'(1);
		end else if (cmd.inv_upd) begin
			r1_q <= r2_q;
			r2_q <= rem_q;
			t1_q <= t2_q;
			t2_q <= sub_mod(t1_q, acc_q, modulus);
		end
		if (cmd.set_res) begin
			res_q <= res_d;
			st_q  <= cmd.res_st;
		end
		if (cmd.out_load) begin
			result_q <= res_q;
			status_q <= st_q;
		end
	end

	assign sts.op      = op_q;
	assign sts.n_zero  = modulus == '0;
	assign sts.a_ge_n  = a_q >= modulus;
	assign sts.r2_zero = r2_q == '0;
	assign sts.r1_one  = r1_q == word_t'(1);
	assign result      = result_q;
	assign status      = status_q;

	`MAU_ASSERT_NXT(a_result_reduced, cmd.out_load && modulus != '0, result_q < modulus, "result not below modulus")
	`MAU_ASSERT_NXT(a_fail_gives_zero, cmd.out_load, !status_q || result_q == '0, "failed inverse with nonzero result")
endmodule
`default_nettype wire

@@ design/mau_ctrl.sv @@
// Controller: sequences reduction, multiplication and Euclid steps, owns the input and output handshakes.
`default_nettype none
`include "modular_arithmetic_unit_defines.svh"
module mau_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire mau_pkg::mau_sts_t sts,
	output mau_pkg::mau_cmd_t      cmd
);
	import mau_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_DIVA, S_DIVB, S_DISP, S_MUL_D, S_MUL_A, S_MUL_END,
		S_ILOOP, S_IDIV, S_FIN
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				if (sts.n_zero || sts.op > OP_INV) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = RES_ZERO;
					cmd.res_st  = sts.op == OP_INV;
					state_d     = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_A;
					cnt_d         = '0;
					state_d       = S_DIVA;
				end
			end
			S_DIVA: begin
				if (cnt_q != CNT_W'(W)) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + CNT_W'(1);
				end else begin
					cmd.save_ar   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_B;
					cnt_d         = '0;
					state_d       = S_DIVB;
				end
			end
			S_DIVB: begin
				if (cnt_q != CNT_W'(W)) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + CNT_W'(1);
				end else begin
					cmd.save_br = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_ADD: begin cmd.set_res = 1'b1; cmd.res_sel = RES_ADD; state_d = S_FIN; end
					OP_SUB: begin cmd.set_res = 1'b1; cmd.res_sel = RES_SUB; state_d = S_FIN; end
					OP_NEG: begin cmd.set_res = 1'b1; cmd.res_sel = RES_NEG; state_d = S_FIN; end
					OP_MUL: begin
						cmd.mul_start = 1'b1;
						cnt_d         = '0;
						state_d       = S_MUL_D;
					end
					OP_INV: begin
						if (sts.a_ge_n) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RES_ZERO;
							cmd.res_st  = 1'b1;
							state_d     = S_FIN;
						end else begin
							cmd.inv_init = 1'b1;
							state_d      = S_ILOOP;
						end
					end
					default: begin cmd.set_res = 1'b1; cmd.res_sel = RES_ZERO; state_d = S_FIN; end
				endcase
			end
			S_MUL_D: begin
				cmd.mul_dbl = 1'b1;
				state_d     = S_MUL_A;
			end
			S_MUL_A: begin
				cmd.mul_add = 1'b1;
				cnt_d       = cnt_q + CNT_W'(1);
				state_d     = (cnt_q == CNT_W'(W - 1)) ? S_MUL_END : S_MUL_D;
			end
			S_MUL_END: begin
				if (sts.op == OP_INV) begin
					cmd.inv_upd = 1'b1;
					state_d     = S_ILOOP;
				end else begin
					cmd.set_res = 1'b1;
					cmd.res_sel = RES_ACC;
					state_d     = S_FIN;
				end
			end
			S_ILOOP: begin
				if (sts.r2_zero) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = sts.r1_one ? RES_T1 : RES_ZERO;
					cmd.res_st  = !sts.r1_one;
					state_d     = S_FIN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_R;
					cnt_d         = '0;
					state_d       = S_IDIV;
				end
			end
			S_IDIV: begin
				if (cnt_q != CNT_W'(W)) begin
					cmd.div_step = 1'b1;
					cnt_d        = cnt_q + CNT_W'(1);
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_inv   = 1'b1;
					cnt_d         = '0;
					state_d       = S_MUL_D;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`MAU_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_q == S_PREP, "accepted transaction not started")
	`MAU_ASSERT_NXT(a_load_shows_result, cmd.out_load, out_valid_q && state_q == S_IDLE, "loaded result not presented")
	`MAU_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_W'(W), "step counter out of range")
endmodule
`default_nettype wire

@@ sim/modular_arithmetic_unit_test.sv @@
// Self-checking testbench for the modular arithmetic unit: directed table plus random phases.
`timescale 1ns / 1ps
module modular_arithmetic_unit_test;
	import mau_pkg::*;

	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam int STALL_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS = 200;
	localparam int NUM_PHASES = 10;

	typedef struct packed {
		logic [31:0] result;
		logic        status;
	} mod_answer_t;

	typedef struct packed {
		logic [31:0] modulus;
		logic [2:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		logic        known;
		logic [31:0] res;
		logic        st;
	} dir_row_t;

	localparam int NUM_DIR = 24;
	localparam logic [31:0] MAXW = 32'hFFFF_FFFF;

	// known = 1 rows carry the answer typed in; others go through the predictor
	dir_row_t dir_tab [0:NUM_DIR-1] = '{
		'{32'd2, OP_ADD, 32'd1, 32'd1, 1'b1, 32'd0, 1'b0},
		'{32'd2, OP_INV, 32'd1, 32'd0, 1'b1, 32'd1, 1'b0},
		'{32'd2, OP_INV, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1},
		'{32'd2, OP_RSVD5, MAXW, MAXW, 1'b1, 32'd0, 1'b0},
		'{32'd2, OP_RSVD7, MAXW, MAXW, 1'b1, 32'd0, 1'b0},
		'{32'd1, OP_INV, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0},
		'{32'd1, OP_ADD, MAXW, MAXW, 1'b1, 32'd0, 1'b0},
		'{32'd0, OP_ADD, MAXW, MAXW, 1'b1, 32'd0, 1'b0},
		'{32'd0, OP_INV, 32'd3, 32'd0, 1'b1, 32'd0, 1'b1},
		'{32'd0, OP_NEG, 32'd5, 32'd0, 1'b1, 32'd0, 1'b0},
		'{MAXW, OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFD, 1'b0},
		'{MAXW, OP_SUB, 32'd0, 32'd1, 1'b1, 32'hFFFF_FFFE, 1'b0},
		'{MAXW, OP_SUB, 32'd5, 32'd5, 1'b1, 32'd0, 1'b0},
		'{MAXW, OP_NEG, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0},
		'{MAXW, OP_NEG, MAXW, 32'd0, 1'b1, 32'd0, 1'b0},
		'{MAXW, OP_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b1, 32'd1, 1'b0},
		'{MAXW, OP_INV, MAXW, 32'd0, 1'b1, 32'd0, 1'b1},
		'{MAXW, OP_INV, 32'hFFFF_FFFE, 32'd0, 1'b1, 32'hFFFF_FFFE, 1'b0},
		'{MAXW, OP_INV, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1},
		'{MAXW, OP_INV, 32'd12345, 32'd0, 1'b0, 32'd0, 1'b0},
		'{32'd10, OP_INV, 32'd4, 32'd0, 1'b1, 32'd0, 1'b1},
		'{32'd10, OP_INV, 32'd3, 32'd0, 1'b1, 32'd7, 1'b0},
		'{32'h8000_0000, OP_MUL, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b0, 32'd0, 1'b0},
		'{32'h8000_0000, OP_SUB, 32'h1234_5678, MAXW, 1'b0, 32'd0, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	word_t       cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  operation;
	word_t       operand_a;
	word_t       operand_b;
	logic        out_valid;
	logic        out_ready;
	word_t       result;
	logic        status;

	modular_arithmetic_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.status    (status)
	);

	mod_answer_t pending_answers[$];
	logic [31:0] cur_modulus;
	bit          idle_on;
	int          fail_count;
	int          items_sent;
	int          answers_seen;
	int          moduli_written;
	int          stall_left;
	int          quiet_cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// reduce-then-operate, with inverse by extended Euclid on signed cofactors
	function automatic mod_answer_t mod_predict(logic [31:0] n, logic [2:0] op,
			logic [31:0] a, logic [31:0] b);
		mod_answer_t ans;
		longint unsigned nn, ar, br;
		longint r1, r2, t1, t2, q, tmp;
		ans = '0;
		nn = 64'(n);
		if (n == 0) begin
			ans.status = (op == OP_INV);
			return ans;
		end
		ar = a % nn;
		br = b % nn;
		case (op)
			OP_ADD: ans.result = 32'((ar + br) % nn);
			OP_SUB: ans.result = 32'((ar + nn - br) % nn);
			OP_MUL: ans.result = 32'((ar * br) % nn);
			OP_NEG: ans.result = 32'((nn - ar) % nn);
			OP_INV: begin
				if (a >= n) begin
					ans.status = 1'b1;
				end else begin
					r1 = nn;
					r2 = longint'(a);
					t1 = 0;
					t2 = 1;
					while (r2 != 0) begin
						q = r1 / r2;
						tmp = r1 - q * r2;
						r1 = r2;
						r2 = tmp;
						tmp = t1 - q * t2;
						t1 = t2;
						t2 = tmp;
					end
					if (r1 != 1)
						ans.status = 1'b1;
					else
						ans.result = 32'((t1 < 0) ? t1 + longint'(nn) : t1);
					if (nn == 1)
						ans.result = 0;
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	function automatic logic [31:0] pick_operand(logic [31:0] n);
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return n - 32'd1;
			2: return MAXW;
			3, 4, 5: return (n == 0) ? $urandom : $urandom % n;
			6: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic write_modulus(logic [31:0] n);
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_modulus = n;
		moduli_written++;
	endtask

	// holds the transaction until accepted, then queues its answer
	task automatic send_op(logic [2:0] op, logic [31:0] a, logic [31:0] b,
			bit typed, mod_answer_t typed_ans);
		int gap;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!in_ready);
		pending_answers.push_back(typed ? typed_ans : mod_predict(cur_modulus, op, a, b));
		items_sent++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		mod_answer_t exp_ans;
		if (arst_n && out_valid && out_ready) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				$error("result transaction with nothing expected: result=%h status=%b",
					result, status);
				fail_count++;
			end else begin
				exp_ans = pending_answers.pop_front();
				if (result !== exp_ans.result) begin
					$error("result: expected %h, got %h", exp_ans.result, result);
					fail_count++;
				end
				if (status !== exp_ans.status) begin
					$error("status: expected %b, got %b", exp_ans.status, status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [31:0] n;
		logic [2:0]  op;
		logic [31:0] a;
		int          drain;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = '0;
		operand_a = '0;
		operand_b = '0;
		quiet_cycles = 0;
		fail_count = 0;
		items_sent = 0;
		answers_seen = 0;
		moduli_written = 0;
		cur_modulus = 32'd2;
		idle_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			if (dir_tab[i].modulus != cur_modulus)
				write_modulus(dir_tab[i].modulus);
			send_op(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].known,
				'{dir_tab[i].res, dir_tab[i].st});
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: n = $urandom_range(1, 20);
				1: n = $urandom;
				2: n = 32'hFFFF_FFFB;
				3: n = 32'd0;
				4: n = 32'd1;
				5: n = 32'h1 << $urandom_range(1, 31);
				6: n = $urandom_range(21, 100000);
				7: n = 32'hFFFF_FFFF;
				8: n = $urandom | 32'h8000_0000;
				default: n = $urandom_range(2, 1000);
			endcase
			write_modulus(n);
			idle_on = (p != NUM_PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// once, let the unit run completely dry before the next transaction
				if (p == 4 && i == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pending_answers.size() != 0);
				end
				case ($urandom_range(0, 19))
					0: op = 3'($urandom_range(5, 7));
					1, 2, 3, 4: op = OP_INV;
					default: op = 3'($urandom_range(0, 3));
				endcase
				a = pick_operand(n);
				send_op(op, a, pick_operand(n), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		drain = 0;
		while (drain < DRAIN_CYCLES) begin
			@(posedge clk);
			drain++;
		end
		$display("covered %0d operations over %0d modulus settings, %0d results checked",
			items_sent, moduli_written + 1, answers_seen);
		$display("moduli included 0, 1, 2, a power of two and 2^32-1; reserved codes included");
		if (fail_count == 0 && pending_answers.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
